/* src/srbs_pkg.sv */
// Shared constants, request type and result codes for sorted_range_bound_search.
// No dependencies; imported by every module of the block but srbs_ram.
package srbs_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int POS_W       = 32;
  localparam int OUT_IDX_W   = 12;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  localparam logic [1:0] ST_CLEARED  = 2'd0;
  localparam logic [1:0] ST_APPENDED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_QUERY    = 2'd3;

  typedef struct packed {
    cmd_code_t        cmd;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_end;
  } req_t;

endpackage

/* src/sorted_range_bound_search.sv */
// Sorted range bound search: a store of appended positions searched for the
// first and last entries inside a queried range. Requests enter a two-entry
// queue; the back end takes one at a time. Clear and append results are
// registered as the request leaves the queue head. A query is handled by a
// read/compare loop on the store's two registered read ports, which run
// the lower-bound and upper-bound searches side by side. Clearing only
// zeroes the entry count, so no clearing pass runs after reset. A finished
// result stays in the result register until popped; the back end takes no
// new request meanwhile, while the front queue keeps accepting up to two
// requests.
// Depends on srbs_pkg, srbs_front, srbs_back.
module sorted_range_bound_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    cmd,
  input  logic [srbs_pkg::POS_W-1:0]     position,
  input  logic [srbs_pkg::POS_W-1:0]     range_start,
  input  logic [srbs_pkg::POS_W-1:0]     range_end,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status,
  output logic                          first_found,
  output logic [srbs_pkg::OUT_IDX_W-1:0] first_index,
  output logic                          last_found,
  output logic [srbs_pkg::OUT_IDX_W-1:0] last_index
);
  import srbs_pkg::*;

  logic             q_valid;
  logic             q_take;
  req_t             q_head;
  logic [CNT_W-1:0] entry_count;

  srbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .position    (position),
    .range_start (range_start),
    .range_end   (range_end),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_take      (q_take)
  );

  srbs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_take      (q_take),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .first_found (first_found),
    .first_index (first_index),
    .last_found  (last_found),
    .last_index  (last_index),
    .entry_count (entry_count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(STORE_DEPTH))
    else $error("entry count above capacity");

  a_nonquery_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_QUERY) |->
      (!first_found && !last_found && first_index == '0 && last_index == '0))
    else $error("non-query result carries search fields");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !first_found) |-> (first_index == '0))
    else $error("first index set without a hit");

  a_take_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("request taken from empty queue");

endmodule

/* src/srbs_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module srbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/srbs_front.sv */
// Front end: accepts requests, drops unknown commands, and holds a two-entry
// request queue for the back end. Depends on srbs_pkg.
module srbs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                cmd,
  input  logic [srbs_pkg::POS_W-1:0] position,
  input  logic [srbs_pkg::POS_W-1:0] range_start,
  input  logic [srbs_pkg::POS_W-1:0] range_end,
  output logic                      q_valid,
  output srbs_pkg::req_t            q_head,
  input  logic                      q_take
);
  import srbs_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       keep;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_head  = slots[rd_ptr];
  assign keep    = push && !full && (cmd_code_t'(cmd) != CMD_NONE);

  always_ff @(posedge clk) begin
    if (keep) begin
      slots[wr_ptr] <= '{cmd: cmd_code_t'(cmd), position: position,
                         range_start: range_start, range_end: range_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, keep} - {1'b0, q_take};
    end
  end

endmodule

/* src/srbs_back.sv */
// Back end: entry count, position store and the two interleaved binary
// searches, with the result register. Depends on srbs_pkg and srbs_ram.
module srbs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  srbs_pkg::req_t                q_head,
  output logic                          q_take,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status,
  output logic                          first_found,
  output logic [srbs_pkg::OUT_IDX_W-1:0] first_index,
  output logic                          last_found,
  output logic [srbs_pkg::OUT_IDX_W-1:0] last_index,
  output logic [srbs_pkg::CNT_W-1:0]     entry_count
);
  import srbs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP} state_t;

  state_t                     state;
  logic                       out_valid;
  logic                       out_set;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           l1, h1, l2, h2, m1r, m2r;
  logic [CNT_W:0]             sum1, sum2;
  logic [CNT_W-1:0]           m1, m2, r2;
  logic                       act1, act2, found1, found2;
  logic [POS_W-1:0]           hv1, lv2, q_start, q_end;
  logic [POS_W-1:0]           rd_a, rd_b;
  logic                       we;
  logic                       pop_ok;
  logic [IDX_W+OUT_IDX_W-1:0] fi_ext, li_ext;

  assign empty       = !out_valid;
  assign entry_count = count;
  assign pop_ok      = pop && out_valid;
  assign q_take      = (state == S_IDLE) && q_valid && (!out_valid || pop);
  assign we          = q_take && (q_head.cmd == CMD_APPEND) &&
                       (count != CNT_W'(STORE_DEPTH));

  // midpoint of [l, h-1]
  assign sum1 = {1'b0, l1} + {1'b0, h1} - {{CNT_W{1'b0}}, 1'b1};
  assign sum2 = {1'b0, l2} + {1'b0, h2} - {{CNT_W{1'b0}}, 1'b1};
  assign m1   = sum1[CNT_W:1];
  assign m2   = sum2[CNT_W:1];
  assign act1 = (l1 < h1);
  assign act2 = (l2 < h2);

  assign found1 = (l1 < count) && (hv1 <= q_end);
  assign found2 = (l2 != '0) && (lv2 >= q_start);
  assign r2     = l2 - {{(CNT_W-1){1'b0}}, 1'b1};
  assign fi_ext = {{OUT_IDX_W{1'b0}}, l1[IDX_W-1:0]};
  assign li_ext = {{OUT_IDX_W{1'b0}}, r2[IDX_W-1:0]};

  assign out_set = (q_take && ((q_head.cmd == CMD_CLEAR) || (q_head.cmd == CMD_APPEND))) ||
                   ((state == S_READ) && !act1 && !act2);

  srbs_ram #(.WIDTH(POS_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (count[IDX_W-1:0]),
    .wdata   (q_head.position),
    .raddr_a (m1[IDX_W-1:0]),
    .rdata_a (rd_a),
    .raddr_b (m2[IDX_W-1:0]),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_take) begin
            case (q_head.cmd)
              CMD_CLEAR: begin
                count       <= '0;
                status      <= ST_CLEARED;
                first_found <= 1'b0;
                first_index <= '0;
                last_found  <= 1'b0;
                last_index  <= '0;
              end
              CMD_APPEND: begin
                if (count == CNT_W'(STORE_DEPTH)) begin
                  status <= ST_DROPPED;
                end else begin
                  status <= ST_APPENDED;
                  count  <= count + {{(CNT_W-1){1'b0}}, 1'b1};
                end
                first_found <= 1'b0;
                first_index <= '0;
                last_found  <= 1'b0;
                last_index  <= '0;
              end
              CMD_QUERY: begin
                l1      <= '0;
                h1      <= count;
                l2      <= '0;
                h2      <= count;
                q_start <= q_head.range_start;
                q_end   <= q_head.range_end;
                state   <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (!act1 && !act2) begin
            status      <= ST_QUERY;
            first_found <= found1;
            first_index <= found1 ? fi_ext[OUT_IDX_W-1:0] : '0;
            last_found  <= found2;
            last_index  <= found2 ? li_ext[OUT_IDX_W-1:0] : '0;
            state       <= S_IDLE;
          end else begin
            m1r   <= m1;
            m2r   <= m2;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (act1) begin
            if (rd_a < q_start) begin
              l1 <= m1r + {{(CNT_W-1){1'b0}}, 1'b1};
            end else begin
              h1  <= m1r;
              hv1 <= rd_a;
            end
          end
          if (act2) begin
            if (rd_b > q_end) begin
              h2 <= m2r;
            end else begin
              l2  <= m2r + {{(CNT_W-1){1'b0}}, 1'b1};
              lv2 <= rd_b;
            end
          end
          state <= S_READ;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/tb_sorted_range_bound_search.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_range_bound_search: queue handshakes on both sides,
// sorted append runs, range queries, a long sorted run and random noise. Depends on srbs_pkg.
module tb_sorted_range_bound_search;
  import srbs_pkg::*;

  localparam int RANDOM_REQUESTS = 1050;
  localparam int CALM_AFTER      = 900;
  localparam int LONG_RUN        = 600;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct packed {
    logic [1:0]           status;
    logic                 first_found;
    logic [OUT_IDX_W-1:0] first_index;
    logic                 last_found;
    logic [OUT_IDX_W-1:0] last_index;
  } search_result_t;

  class bound_search_scoreboard;
    logic [POS_W-1:0] positions [STORE_DEPTH];
    int entry_count = 0;
    int errors = 0;
    search_result_t expected_results[$];

    function search_result_t predict_query(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      search_result_t r;
      int l;
      int h;
      int m;
      r = '0;
      r.status = ST_QUERY;
      l = 0;
      h = entry_count - 1;
      while (l <= h) begin
        m = (l + h) / 2;
        if (positions[m] < lo) l = m + 1;
        else h = m - 1;
      end
      if (l < entry_count && positions[l] <= hi) begin
        r.first_found = 1'b1;
        r.first_index = l[OUT_IDX_W-1:0];
      end
      l = 0;
      h = entry_count - 1;
      while (l <= h) begin
        m = (l + h) / 2;
        if (positions[m] > hi) h = m - 1;
        else l = m + 1;
      end
      if (h >= 0 && positions[h] >= lo) begin
        r.last_found = 1'b1;
        r.last_index = h[OUT_IDX_W-1:0];
      end
      return r;
    endfunction

    function void note_request(cmd_code_t c, logic [POS_W-1:0] pos, logic [POS_W-1:0] lo,
                               logic [POS_W-1:0] hi);
      search_result_t r;
      r = '0;
      case (c)
        CMD_CLEAR: begin
          entry_count = 0;
          r.status = ST_CLEARED;
        end
        CMD_APPEND: begin
          if (entry_count >= STORE_DEPTH) begin
            r.status = ST_DROPPED;
          end else begin
            positions[entry_count] = pos;
            entry_count++;
            r.status = ST_APPENDED;
          end
        end
        CMD_QUERY: r = predict_query(lo, hi);
        default: return;
      endcase
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual status %0h",
                 $time, got.status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("first_found", want.first_found, got.first_found);
      compare_field("first_index", want.first_index, got.first_index);
      compare_field("last_found", want.last_found, got.last_found);
      compare_field("last_index", want.last_index, got.last_index);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           cmd = CMD_NONE;
  logic [POS_W-1:0]     position = '0;
  logic [POS_W-1:0]     range_start = '0;
  logic [POS_W-1:0]     range_end = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [1:0]           status;
  logic                 first_found;
  logic [OUT_IDX_W-1:0] first_index;
  logic                 last_found;
  logic [OUT_IDX_W-1:0] last_index;

  bound_search_scoreboard sb = new;
  bit calm = 1'b0;
  int send_idle_pct = 20;
  int recv_idle_pct = 20;
  int requests_sent = 0;
  int stall_cycles = 0;

  sorted_range_bound_search dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .position    (position),
    .range_start (range_start),
    .range_end   (range_end),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .first_found (first_found),
    .first_index (first_index),
    .last_found  (last_found),
    .last_index  (last_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_request(cmd_code_t c, logic [POS_W-1:0] pos, logic [POS_W-1:0] lo,
                              logic [POS_W-1:0] hi);
    if (!calm && $urandom_range(1, 100) <= send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push        <= 1'b1;
    cmd         <= c;
    position    <= pos;
    range_start <= lo;
    range_end   <= hi;
    do @(posedge clk); while (full);
    sb.note_request(c, pos, lo, hi);
    if (c != CMD_NONE) requests_sent++;
  endtask

  // mostly near stored values so the searches land on hits, neighbors and gaps
  function automatic logic [POS_W-1:0] pick_bound();
    logic [POS_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3: v = $urandom;
      default: begin
        if (sb.entry_count == 0) begin
          v = $urandom;
        end else begin
          v = sb.positions[$urandom_range(0, sb.entry_count - 1)];
          case ($urandom_range(0, 2))
            1: if (v != '1) v = v + 1;
            2: if (v != '0) v = v - 1;
            default: ;
          endcase
        end
      end
    endcase
    return v;
  endfunction

  task automatic send_query();
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] t;
    lo = pick_bound();
    hi = pick_bound();
    if (lo > hi && $urandom_range(0, 4) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    send_request(CMD_QUERY, $urandom, lo, hi);
  endtask

  task automatic append_sorted(int n, logic [POS_W-1:0] first, int unsigned max_step);
    longint unsigned v;
    v = first;
    repeat (n) begin
      send_request(CMD_APPEND, v[POS_W-1:0], $urandom, $urandom);
      if ($urandom_range(0, 3) != 0) v += $urandom_range(1, max_step);
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    end
  endtask

  function automatic logic [POS_W-1:0] pick_run_start();
    if (sb.entry_count > 0 && $urandom_range(0, 1) == 0)
      return sb.positions[sb.entry_count - 1];
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 50);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 5000);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 3))
      0: return 1;
      1: return 16;
      2: return 1000;
      default: return 1 << 24;
    endcase
  endfunction

  initial begin
    int random_base;
    int done;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_QUERY, '0, '0, '1);
    send_request(CMD_NONE, '1, '1, '1);
    send_request(CMD_APPEND, 32'd0, '0, '0);
    send_request(CMD_APPEND, 32'd5, '0, '0);
    send_request(CMD_APPEND, 32'd5, '0, '0);
    send_request(CMD_APPEND, 32'd100, '0, '0);
    send_request(CMD_APPEND, 32'hFFFF_FFFF, '0, '0);
    send_request(CMD_QUERY, '0, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, '0, 32'd5, 32'd5);
    send_request(CMD_QUERY, '0, 32'd6, 32'd99);
    send_request(CMD_QUERY, '0, 32'd100, 32'd5);
    send_request(CMD_QUERY, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, '0, 32'd1, 32'd4);
    send_request(CMD_QUERY, '0, 32'd101, 32'hFFFF_FFFE);
    send_request(CMD_NONE, '0, '0, '0);
    send_request(CMD_CLEAR, '1, '1, '1);
    send_request(CMD_QUERY, '0, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_APPEND, 32'd7, '0, '0);
    send_request(CMD_APPEND, 32'd3, '0, '0);
    send_request(CMD_QUERY, '0, 32'd3, 32'd7);
    send_request(CMD_QUERY, '0, 32'd0, 32'd5);
    send_request(CMD_CLEAR, '0, '0, '0);

    // one long sorted run, then search it
    append_sorted(LONG_RUN, $urandom_range(0, 1000), 1 << 20);
    send_request(CMD_QUERY, '0, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, '0, sb.positions[0], sb.positions[sb.entry_count-1]);
    send_request(CMD_QUERY, '0, sb.positions[sb.entry_count-1], 32'hFFFF_FFFF);
    repeat (25) send_query();
    send_request(CMD_CLEAR, '0, '0, '0);

    random_base = requests_sent;
    while (requests_sent - random_base < RANDOM_REQUESTS) begin
      done = requests_sent - random_base;
      calm = (done >= CALM_AFTER);
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 50;
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          send_request(cmd_code_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end
        3, 4, 5, 6, 7: begin
          repeat ($urandom_range(1, 4)) send_query();
        end
        default: begin
          if ($urandom_range(0, 4) != 0) send_request(CMD_CLEAR, $urandom, $urandom, $urandom);
          append_sorted(($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                     : $urandom_range(0, 24),
                        pick_run_start(), pick_step());
          repeat ($urandom_range(1, 8)) send_query();
        end
      endcase
    end
    push <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    search_result_t got;
    int pops;
    pops = 0;
    wait (rst == 1'b0);
    forever begin
      if (!calm && $urandom_range(1, 100) <= recv_idle_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) begin
        got.status      = status;
        got.first_found = first_found;
        got.first_index = first_index;
        got.last_found  = last_found;
        got.last_index  = last_index;
        sb.check_result(got);
        pops++;
        if (pops % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 15;
            default: recv_idle_pct = 40;
          endcase
        end
      end
    end
  end

  // no request moving on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no request accepted for %0d cycles", $time, stall_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
